[hdl/leb_pkg.sv]
// ----------------------------------------------------------------------------
// leb_pkg
// shared types, codes and sizes of the line edit buffer
// ----------------------------------------------------------------------------
package leb_pkg;

  // edit store geometry
  localparam int BUFFER_DEPTH = 32;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int COUNT_W      = 6;
  localparam int CHAR_W       = 7;

  // input commands
  localparam logic [1:0] CMD_CHAR   = 2'd0;
  localparam logic [1:0] CMD_ABORT  = 2'd1;
  localparam logic [1:0] CMD_EOF    = 2'd2;
  localparam logic [1:0] CMD_SILENT = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_CHAR    = 3'd0;
  localparam logic [2:0] KIND_RESTART = 3'd1;
  localparam logic [2:0] KIND_ABORT   = 3'd2;
  localparam logic [2:0] KIND_EOF     = 3'd3;
  localparam logic [2:0] KIND_BELL    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_ERASE      = 2'd0;
  localparam logic [1:0] REG_WORD_ERASE = 2'd1;
  localparam logic [1:0] REG_LINE_ERASE = 2'd2;
  localparam logic [1:0] REG_LITERAL    = 2'd3;

  // blank characters for word erase
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 7'h09;

  // edit key codes
  typedef struct packed {
    logic [CHAR_W-1:0] erase_char;
    logic [CHAR_W-1:0] word_erase_char;
    logic [CHAR_W-1:0] line_erase_char;
    logic [CHAR_W-1:0] literal_char;
  } keys_t;

  // one result pushed toward the output stage
  typedef struct packed {
    logic              push;
    logic [2:0]        kind;
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } result_t;

endpackage

[hdl/leb_ram.sv]
// ----------------------------------------------------------------------------
// leb_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/leb_ctrl.sv]
// ----------------------------------------------------------------------------
// leb_ctrl
// edit sequencer: decodes keys, walks the edit store for word erase and replay
// ----------------------------------------------------------------------------
module leb_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [7:0]                    raw_char,
  input  leb_pkg::keys_t                keys,
  input  logic                          can_push,
  output leb_pkg::result_t              res,
  output logic                          wr_en,
  output logic [leb_pkg::ADDR_W-1:0]    wr_addr,
  output logic [leb_pkg::CHAR_W-1:0]    wr_data,
  output logic                          rd_en,
  output logic [leb_pkg::ADDR_W-1:0]    rd_addr,
  input  logic [leb_pkg::CHAR_W-1:0]    rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WE_RD,
    S_WE_CHK,
    S_RP_RD,
    S_RP_OUT
  } state_t;

  state_t                         state;
  logic [leb_pkg::COUNT_W-1:0]    fill;
  logic [leb_pkg::COUNT_W-1:0]    idx;
  logic                           literal_pending;
  logic                           blank_phase;
  logic [2:0]                     head_kind;
  logic [leb_pkg::CHAR_W-1:0]     head_char;
  logic                           head_replay;

  logic                           accept;
  logic [leb_pkg::CHAR_W-1:0]     ch;
  logic                           store_path;
  logic                           store_room;
  logic                           rd_blank;
  logic [leb_pkg::COUNT_W-1:0]    fill_dec;
  logic [leb_pkg::COUNT_W-1:0]    idx_inc;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign ch         = raw_char[leb_pkg::CHAR_W-1:0];
  assign store_room = fill < leb_pkg::COUNT_W'(leb_pkg::BUFFER_DEPTH);
  assign rd_blank   = (rd_data == leb_pkg::CHAR_SPACE) || (rd_data == leb_pkg::CHAR_TAB);
  assign fill_dec   = fill - leb_pkg::COUNT_W'(1);
  assign idx_inc    = idx + leb_pkg::COUNT_W'(1);

  // a character goes to the store: literal, or no edit key matches
  always_comb begin
    store_path = 1'b0;
    if (cmd == leb_pkg::CMD_CHAR) begin
      if (literal_pending) begin
        store_path = 1'b1;
      end else if (ch != keys.literal_char && ch != keys.erase_char &&
                   ch != keys.word_erase_char && ch != keys.line_erase_char) begin
        store_path = 1'b1;
      end
    end
  end

  assign wr_en   = accept && store_path && store_room;
  assign wr_addr = fill[leb_pkg::ADDR_W-1:0];
  assign wr_data = ch;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = fill_dec[leb_pkg::ADDR_W-1:0];
    if (state == S_WE_RD && fill != '0) begin
      rd_en = 1'b1;
    end else if (state == S_RP_RD) begin
      rd_en   = 1'b1;
      rd_addr = idx[leb_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    res          = '0;
    res.kind     = head_kind;
    res.char_out = head_char;
    if (state == S_HEAD) begin
      res.push = can_push;
      res.last = !head_replay || (fill == '0);
    end else if (state == S_RP_OUT) begin
      res.push     = can_push;
      res.kind     = leb_pkg::KIND_CHAR;
      res.char_out = rd_data;
      res.last     = (idx_inc == fill);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      fill            <= '0;
      idx             <= '0;
      literal_pending <= 1'b0;
      blank_phase     <= 1'b0;
      head_kind       <= leb_pkg::KIND_CHAR;
      head_char       <= '0;
      head_replay     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            head_char   <= '0;
            head_replay <= 1'b0;
            unique case (cmd)
              leb_pkg::CMD_ABORT: begin
                fill            <= '0;
                literal_pending <= 1'b0;
                head_kind       <= leb_pkg::KIND_ABORT;
                state           <= S_HEAD;
              end
              leb_pkg::CMD_EOF: begin
                head_kind   <= leb_pkg::KIND_EOF;
                head_replay <= 1'b1;
                state       <= S_HEAD;
              end
              leb_pkg::CMD_SILENT: begin
                fill            <= '0;
                literal_pending <= 1'b0;
              end
              default: begin
                literal_pending <= 1'b0;
                if (store_path) begin
                  if (store_room) begin
                    fill      <= fill + leb_pkg::COUNT_W'(1);
                    head_kind <= leb_pkg::KIND_CHAR;
                    head_char <= ch;
                  end else begin
                    head_kind <= leb_pkg::KIND_BELL;
                  end
                  state <= S_HEAD;
                end else if (ch == keys.literal_char) begin
                  literal_pending <= 1'b1;
                end else if (ch == keys.erase_char) begin
                  if (fill == '0) begin
                    head_kind <= leb_pkg::KIND_BELL;
                  end else begin
                    fill        <= fill_dec;
                    head_kind   <= leb_pkg::KIND_RESTART;
                    head_replay <= 1'b1;
                  end
                  state <= S_HEAD;
                end else if (ch == keys.word_erase_char) begin
                  if (fill != '0) begin
                    blank_phase <= 1'b1;
                    state       <= S_WE_RD;
                  end
                end else if (fill != '0) begin
                  // line erase
                  fill      <= '0;
                  head_kind <= leb_pkg::KIND_RESTART;
                  state     <= S_HEAD;
                end
              end
            endcase
          end
        end
        S_HEAD: begin
          if (can_push) begin
            idx <= '0;
            if (head_replay && fill != '0) begin
              state <= S_RP_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_WE_RD: begin
          if (fill == '0) begin
            head_kind   <= leb_pkg::KIND_RESTART;
            head_replay <= 1'b1;
            state       <= S_HEAD;
          end else begin
            state <= S_WE_CHK;
          end
        end
        S_WE_CHK: begin
          // trailing blanks first, then the word before them
          if (blank_phase || !rd_blank) begin
            if (!rd_blank) begin
              blank_phase <= 1'b0;
            end
            fill  <= fill_dec;
            state <= S_WE_RD;
          end else begin
            head_kind   <= leb_pkg::KIND_RESTART;
            head_replay <= 1'b1;
            state       <= S_HEAD;
          end
        end
        S_RP_RD: begin
          state <= S_RP_OUT;
        end
        S_RP_OUT: begin
          if (can_push) begin
            idx <= idx_inc;
            if (idx_inc == fill) begin
              state <= S_IDLE;
            end else begin
              state <= S_RP_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/line_edit_buffer.sv]
// ----------------------------------------------------------------------------
// line_edit_buffer
// terminal line editor with erase, word erase, line erase and literal keys
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | transaction
//  ---------+----------------------------------+------------------------------
//  input    | in_valid/in_ready, cmd, raw_char | one command or key
//  output   | out_valid/out_ready, kind,       | one result, last marks the
//           | char_out, last                   | final one of a command
//  config   | cfg_wr_en, cfg_index, cfg_data   | one key register write
//
//  an ordinary key's result is formed in the head state and loaded into the output
//  register as the sequencer returns to idle for the next key; a replay takes each
//  stored character in turn (store read, then output), and word erase reads and checks
//  each removed character plus one closing check, all set by the store read port
//  one command is worked on at a time; in_ready is high only when idle
//  the output register holds a result while out_ready is low and the
//  sequencer waits; a new command is taken while the last result still waits
//  rst is synchronous: store empty, literal flag clear, keys at defaults
//
module line_edit_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic [7:0]                 raw_char,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 kind,
  output logic [leb_pkg::CHAR_W-1:0] char_out,
  output logic                       last,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [leb_pkg::CHAR_W-1:0] cfg_data
);

  leb_pkg::keys_t                 keys;
  leb_pkg::result_t               res;
  logic                           can_push;
  logic                           wr_en;
  logic [leb_pkg::ADDR_W-1:0]     wr_addr;
  logic [leb_pkg::CHAR_W-1:0]     wr_data;
  logic                           rd_en;
  logic [leb_pkg::ADDR_W-1:0]     rd_addr;
  logic [leb_pkg::CHAR_W-1:0]     rd_data;

  // key registers; write them only while the block is idle (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (rst) begin
      keys.erase_char      <= 7'd35;
      keys.word_erase_char <= 7'd23;
      keys.line_erase_char <= 7'd64;
      keys.literal_char    <= 7'd22;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        leb_pkg::REG_ERASE:      keys.erase_char      <= cfg_data;
        leb_pkg::REG_WORD_ERASE: keys.word_erase_char <= cfg_data;
        leb_pkg::REG_LINE_ERASE: keys.line_erase_char <= cfg_data;
        default:                 keys.literal_char    <= cfg_data;
      endcase
    end
  end

  // output register: takes a new result when empty or being drained
  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_push) begin
      out_valid <= res.push;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res.push) begin
      kind     <= res.kind;
      char_out <= res.char_out;
      last     <= res.last;
    end
  end

  // edit store
  leb_ram #(
    .WIDTH (leb_pkg::CHAR_W),
    .DEPTH (leb_pkg::BUFFER_DEPTH),
    .AW    (leb_pkg::ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // key decode and store walking
  leb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .raw_char (raw_char),
    .keys     (keys),
    .can_push (can_push),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

endmodule

[hdl/leb_checker.sv]
// ----------------------------------------------------------------------------
// leb_checker
// port-level assertions on the line edit buffer
// ----------------------------------------------------------------------------
module leb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [2:0]                 kind,
  input logic [leb_pkg::CHAR_W-1:0] char_out,
  input logic                       last
);

  // nothing is offered right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_out) &&
    $stable(last))
    else $error("stalled result changed");

  // only character results carry a character
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != leb_pkg::KIND_CHAR |-> char_out == '0)
    else $error("non-character result with character bits");

  // abort and bell always stand alone
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == leb_pkg::KIND_ABORT || kind == leb_pkg::KIND_BELL) |-> last)
    else $error("abort or bell not final");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .char_out  (char_out),
  .last      (last)
);

[tb/line_edit_buffer_test.sv]
// ----------------------------------------------------------------------------
// line_edit_buffer_test
// self-checking bench for the terminal line editor: a short directed table
// covers empty-store edits, character extremes, the literal key, abort, eof
// and silent reset; random phases follow, each with its own edit keys (typical,
// extreme and colliding codes), typing words, erasing, filling the store to
// the bell and replaying it, all checked against an in-bench line model
// ----------------------------------------------------------------------------
module line_edit_buffer_test;

  // how each directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,  // expectation comes from the line model
    CHK_NONE  = 2'd1,  // no result at all
    CHK_ONE   = 2'd2   // one result, typed in the row, last set
  } chk_t;

  typedef struct packed {
    logic [1:0]                 op;
    logic [7:0]                 raw;
    chk_t                       chk;
    logic [2:0]                 kind;
    logic [leb_pkg::CHAR_W-1:0] ch;
  } row_t;

  // one echo result as seen on the output channel
  typedef struct packed {
    logic [2:0]                 kind;
    logic [leb_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } echo_t;

  localparam int RAND_ITEMS     = 295;
  localparam int PHASE_ITEMS    = 46;
  localparam int SETTLE_CYCLES  = 4 * leb_pkg::BUFFER_DEPTH + 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIR_ROWS       = 27;

  // default keys: erase '#', word erase ^W, line erase '@', literal ^V
  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{leb_pkg::CMD_CHAR,   8'h23, CHK_ONE,   leb_pkg::KIND_BELL,    7'h00},  // erase, empty
    '{leb_pkg::CMD_CHAR,   8'h17, CHK_NONE,  leb_pkg::KIND_CHAR,    7'h00},  // word erase
    '{leb_pkg::CMD_CHAR,   8'h40, CHK_NONE,  leb_pkg::KIND_CHAR,    7'h00},  // line erase
    '{leb_pkg::CMD_EOF,    8'h00, CHK_ONE,   leb_pkg::KIND_EOF,     7'h00},  // nothing to replay
    '{leb_pkg::CMD_ABORT,  8'h40, CHK_ONE,   leb_pkg::KIND_ABORT,   7'h00},  // key ignored
    '{leb_pkg::CMD_CHAR,   8'h00, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h00},
    '{leb_pkg::CMD_CHAR,   8'hff, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h7f},
    '{leb_pkg::CMD_CHAR,   8'h80, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h00},  // top bit dropped
    '{leb_pkg::CMD_CHAR,   8'h20, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h20},
    '{leb_pkg::CMD_CHAR,   8'h09, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h09},
    '{leb_pkg::CMD_CHAR,   8'he1, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h61},
    '{leb_pkg::CMD_CHAR,   8'h62, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h62},
    '{leb_pkg::CMD_CHAR,   8'h20, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h20},
    '{leb_pkg::CMD_CHAR,   8'h17, CHK_MODEL, leb_pkg::KIND_CHAR,    7'h00},  // trailing blank
    '{leb_pkg::CMD_CHAR,   8'h23, CHK_MODEL, leb_pkg::KIND_CHAR,    7'h00},  // erase, replay
    '{leb_pkg::CMD_EOF,    8'h5a, CHK_MODEL, leb_pkg::KIND_CHAR,    7'h00},  // eof, replay
    '{leb_pkg::CMD_CHAR,   8'h16, CHK_NONE,  leb_pkg::KIND_CHAR,    7'h00},  // literal key
    '{leb_pkg::CMD_CHAR,   8'ha3, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h23},  // literal erase
    '{leb_pkg::CMD_CHAR,   8'h16, CHK_NONE,  leb_pkg::KIND_CHAR,    7'h00},
    '{leb_pkg::CMD_CHAR,   8'h96, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h16},  // literal literal
    '{leb_pkg::CMD_CHAR,   8'h16, CHK_NONE,  leb_pkg::KIND_CHAR,    7'h00},
    '{leb_pkg::CMD_ABORT,  8'h00, CHK_ONE,   leb_pkg::KIND_ABORT,   7'h00},  // flag dropped
    '{leb_pkg::CMD_CHAR,   8'h41, CHK_ONE,   leb_pkg::KIND_CHAR,    7'h41},
    '{leb_pkg::CMD_CHAR,   8'h40, CHK_ONE,   leb_pkg::KIND_RESTART, 7'h00},  // line erase
    '{leb_pkg::CMD_CHAR,   8'h16, CHK_NONE,  leb_pkg::KIND_CHAR,    7'h00},
    '{leb_pkg::CMD_SILENT, 8'h23, CHK_NONE,  leb_pkg::KIND_CHAR,    7'h00},  // silent reset
    '{leb_pkg::CMD_CHAR,   8'h23, CHK_ONE,   leb_pkg::KIND_BELL,    7'h00}   // empty again
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 cmd = leb_pkg::CMD_CHAR;
  logic [7:0]                 raw_char = 8'h00;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 kind;
  logic [leb_pkg::CHAR_W-1:0] char_out;
  logic                       last;
  logic                       cfg_wr_en = 1'b0;
  logic [1:0]                 cfg_index = leb_pkg::REG_ERASE;
  logic [leb_pkg::CHAR_W-1:0] cfg_data = '0;

  line_edit_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .raw_char  (raw_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .char_out  (char_out),
    .last      (last),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // line model state: stored characters, fill, literal flag and edit keys
  logic [leb_pkg::CHAR_W-1:0] line_store [leb_pkg::BUFFER_DEPTH];
  int                         line_fill = 0;
  bit                         lit_armed = 1'b0;
  leb_pkg::keys_t             edit_keys = '{7'd35, 7'd23, 7'd64, 7'd22};

  echo_t step_q [$];  // echoes of the transaction just accepted
  echo_t echo_q [$];  // echoes still owed by the block
  int    fail_count = 0;
  int    rand_items = 0;
  int    idle_cycles = 0;
  bit    quiet = 1'b0;  // no idling on either side while set

  // ---------------------------------------------------------------------------
  // line model
  // ---------------------------------------------------------------------------
  function automatic void emit_echo(input logic [2:0] k,
                                    input logic [leb_pkg::CHAR_W-1:0] c);
    echo_t e;
    e.kind = k;
    e.ch   = c;
    e.last = 1'b0;
    step_q.push_back(e);
  endfunction

  function automatic void emit_replay();
    for (int i = 0; i < line_fill; i++) emit_echo(leb_pkg::KIND_CHAR, line_store[i]);
  endfunction

  function automatic bit is_blank(input logic [leb_pkg::CHAR_W-1:0] c);
    return c == leb_pkg::CHAR_SPACE || c == leb_pkg::CHAR_TAB;
  endfunction

  // full store rings the bell instead of storing
  function automatic void store_key(input logic [leb_pkg::CHAR_W-1:0] c);
    if (line_fill >= leb_pkg::BUFFER_DEPTH) begin
      emit_echo(leb_pkg::KIND_BELL, '0);
    end else begin
      line_store[line_fill] = c;
      line_fill++;
      emit_echo(leb_pkg::KIND_CHAR, c);
    end
  endfunction

  // apply one accepted transaction to the line, leaving its echoes in step_q
  function automatic void edit_line(input logic [1:0] c, input logic [7:0] raw);
    logic [leb_pkg::CHAR_W-1:0] k;
    echo_t                      e;
    k = raw[leb_pkg::CHAR_W-1:0];
    step_q.delete();
    case (c)
      leb_pkg::CMD_ABORT: begin
        line_fill = 0;
        lit_armed = 1'b0;
        emit_echo(leb_pkg::KIND_ABORT, '0);
      end
      leb_pkg::CMD_EOF: begin
        emit_echo(leb_pkg::KIND_EOF, '0);
        emit_replay();
      end
      leb_pkg::CMD_SILENT: begin
        line_fill = 0;
        lit_armed = 1'b0;
      end
      default: begin
        // literal flag first, then literal, erase, word erase, line erase
        if (lit_armed) begin
          lit_armed = 1'b0;
          store_key(k);
        end else if (k == edit_keys.literal_char) begin
          lit_armed = 1'b1;
        end else if (k == edit_keys.erase_char) begin
          if (line_fill == 0) begin
            emit_echo(leb_pkg::KIND_BELL, '0);
          end else begin
            line_fill--;
            emit_echo(leb_pkg::KIND_RESTART, '0);
            emit_replay();
          end
        end else if (k == edit_keys.word_erase_char) begin
          if (line_fill != 0) begin
            while (line_fill > 0 && is_blank(line_store[line_fill-1])) line_fill--;
            while (line_fill > 0 && !is_blank(line_store[line_fill-1])) line_fill--;
            emit_echo(leb_pkg::KIND_RESTART, '0);
            emit_replay();
          end
        end else if (k == edit_keys.line_erase_char) begin
          if (line_fill != 0) begin
            line_fill = 0;
            emit_echo(leb_pkg::KIND_RESTART, '0);
          end
        end else begin
          store_key(k);
        end
      end
    endcase
    if (step_q.size() != 0) begin
      e = step_q.pop_back();
      e.last = 1'b1;
      step_q.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // present one transaction, maybe after a random gap, and wait for acceptance
  task automatic send_key(input logic [1:0] c, input logic [7:0] raw);
    if (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(99) < 19);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    raw_char <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edit_line(c, raw);
  endtask

  task automatic send_pred(input logic [1:0] c, input logic [7:0] raw);
    send_key(c, raw);
    foreach (step_q[i]) echo_q.push_back(step_q[i]);
    rand_items++;
  endtask

  // hold the sender until every echo is back, then let silent work finish
  task automatic drain_results();
    in_valid <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_keys(input leb_pkg::keys_t k);
    cfg_wr_en <= 1'b1;
    cfg_index <= leb_pkg::REG_ERASE;
    cfg_data  <= k.erase_char;
    @(posedge clk);
    cfg_index <= leb_pkg::REG_WORD_ERASE;
    cfg_data  <= k.word_erase_char;
    @(posedge clk);
    cfg_index <= leb_pkg::REG_LINE_ERASE;
    cfg_data  <= k.line_erase_char;
    @(posedge clk);
    cfg_index <= leb_pkg::REG_LITERAL;
    cfg_data  <= k.literal_char;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    edit_keys = k;
  endtask

  // typical codes, extremes, full collision (literal wins), erase winning over
  // word and line erase, a blank as literal key, then random codes
  function automatic leb_pkg::keys_t phase_keys(input int p);
    leb_pkg::keys_t k;
    case (p)
      0:       k = '{7'h7f, 7'h17, 7'h15, 7'h16};
      1:       k = '{7'h00, 7'h7f, 7'h01, 7'h7e};
      2:       k = '{7'h08, 7'h08, 7'h08, 7'h08};
      3:       k = '{7'h7f, 7'h7f, 7'h7f, 7'h00};
      4:       k = '{7'h2e, 7'h2d, 7'h2d, 7'h20};
      default: k = '{7'($urandom_range(127)), 7'($urandom_range(127)),
                     7'($urandom_range(127)), 7'($urandom_range(127))};
    endcase
    return k;
  endfunction

  // lowercase letter, top bit random since the block drops it
  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(25));
    c[7] = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    logic [7:0] c;
    c = ($urandom_range(1) != 0) ? {1'b0, leb_pkg::CHAR_SPACE} : {1'b0, leb_pkg::CHAR_TAB};
    c[7] = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic logic [7:0] pick_edit_key();
    logic [7:0] c;
    case ($urandom_range(3))
      0:       c = {1'b0, edit_keys.erase_char};
      1:       c = {1'b0, edit_keys.word_erase_char};
      2:       c = {1'b0, edit_keys.line_erase_char};
      default: c = {1'b0, edit_keys.literal_char};
    endcase
    c[7] = 1'($urandom_range(1));
    return c;
  endfunction

  // words with blanks between them, edit keys mixed in, then an optional closing eof or edit
  task automatic type_words();
    int nwords;
    int nchars;
    nwords = $urandom_range(1, 4);
    repeat (nwords) begin
      nchars = $urandom_range(1, 6);
      repeat (nchars) begin
        if ($urandom_range(99) < 12) send_pred(leb_pkg::CMD_CHAR, pick_edit_key());
        else send_pred(leb_pkg::CMD_CHAR, pick_letter());
      end
      repeat ($urandom_range(1, 2)) send_pred(leb_pkg::CMD_CHAR, pick_blank());
    end
    case ($urandom_range(3))
      0: send_pred(leb_pkg::CMD_EOF, 8'($urandom_range(255)));
      1: send_pred(leb_pkg::CMD_CHAR, pick_edit_key());
      2: begin
        send_pred(leb_pkg::CMD_CHAR, pick_edit_key());
        send_pred(leb_pkg::CMD_CHAR, pick_edit_key());
      end
      default: ;
    endcase
  endtask

  // run the store past full, try a literal while full, replay the full line
  task automatic fill_line();
    repeat (leb_pkg::BUFFER_DEPTH - line_fill + $urandom_range(1, 3))
      send_pred(leb_pkg::CMD_CHAR, pick_letter());
    send_pred(leb_pkg::CMD_CHAR, {1'b0, edit_keys.literal_char});
    send_pred(leb_pkg::CMD_CHAR, pick_letter());
    send_pred(leb_pkg::CMD_EOF, 8'($urandom_range(255)));
    send_pred(leb_pkg::CMD_CHAR, pick_edit_key());
  endtask

  task automatic run_scenario();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      type_words();
    end else if (pick < 70) begin
      fill_line();
    end else if (pick < 80) begin
      send_pred(2'($urandom_range(1, 3)), 8'($urandom_range(255)));
    end else begin
      // noise: any command with any byte
      repeat ($urandom_range(1, 6)) send_pred(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, each result transaction checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    echo_t want;
    if (!rst && out_valid && out_ready) begin
      if (echo_q.size() == 0) begin
        $display("%0t: result with nothing expected: kind %0d char %h last %b",
                 $time, kind, char_out, last);
        fail_count++;
      end else begin
        want = echo_q.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
          fail_count++;
        end
        if (char_out !== want.ch) begin
          $display("%0t: char_out expected %h actual %h", $time, want.ch, char_out);
          fail_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last);
          fail_count++;
        end
      end
    end
    out_ready <= quiet || ($urandom_range(99) >= 19);
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("line_edit_buffer verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    echo_t typed;
    int    phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset keys
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_key(DIRECTED[r].op, DIRECTED[r].raw);
      case (DIRECTED[r].chk)
        CHK_MODEL: foreach (step_q[i]) echo_q.push_back(step_q[i]);
        CHK_ONE: begin
          typed = '{DIRECTED[r].kind, DIRECTED[r].ch, 1'b1};
          echo_q.push_back(typed);
        end
        default: ;
      endcase
    end

    // random phases, keys rewritten only once the block is idle
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      drain_results();
      load_keys(phase_keys(phase));
      quiet = (phase == 2);
      while (rand_items < RAND_ITEMS && rand_items < (phase + 1) * PHASE_ITEMS) run_scenario();
      quiet = 1'b0;
      phase++;
    end

    drain_results();
    if (fail_count == 0) begin
      $display("line_edit_buffer verification clean");
    end else begin
      $display("line_edit_buffer verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/leb_pkg.sv
hdl/leb_ram.sv
hdl/leb_ctrl.sv
hdl/line_edit_buffer.sv
hdl/leb_checker.sv
tb/line_edit_buffer_test.sv
